@@ rtl/fepm_pkg.sv @@
// shared types, constants and helpers for the fibonacci exponent modular power block
`default_nettype none
package fepm_pkg;

  localparam int IN_W     = 62;
  localparam int RES_W    = 30;
  localparam int FIB_STEPS = 62;
  localparam int POW_STEPS = 30;
  localparam int FIB_CNT_W = $clog2(FIB_STEPS);
  localparam int POW_CNT_W = $clog2(POW_STEPS);

  localparam logic [29:0] MOD_P   = 30'd1000000007;
  localparam logic [29:0] MOD_E   = 30'd1000000006;
  // floor(2^60 / m) for the two moduli
  localparam logic [30:0] MU_P    = 31'd1152921496;
  localparam logic [30:0] MU_E    = 31'd1152921497;
  // 2^32 mod MOD_P
  localparam logic [29:0] TWO32_P = 30'd294967268;

  typedef struct packed {
    logic [IN_W-1:0] base_w;
    logic [IN_W-1:0] base_x;
    logic [IN_W-1:0] index_n;
  } item_t;

  typedef struct packed {
    logic [RES_W-1:0] product_mod;
    logic             bad_index;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RED_W,
    OP_RED_X,
    OP_WX,
    OP_FIB_S,
    OP_FIB_D,
    OP_FIB_T,
    OP_POW_SQ,
    OP_POW_MUL
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_W,
    S_RED_X,
    S_WX,
    S_FIB_S,
    S_FIB_D,
    S_FIB_T,
    S_FIB_NEXT,
    S_POW_INIT,
    S_POW_SQ,
    S_POW_MUL,
    S_POW_NEXT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    op_t  op;
    logic fib_step;
    logic pow_init;
    logic pow_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic index_zero;
    logic mul_done;
    logic fib_last;
    logic pow_sel;
    logic pow_last;
  } status_t;

  // reduce a value known to be below 3*m
  function automatic logic [29:0] mod_fix(input logic [31:0] v, input logic [29:0] m);
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] r;
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    if (v >= m2) begin
      r = v - m2;
    end else if (v >= m1) begin
      r = v - m1;
    end else begin
      r = v;
    end
    return r[29:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/fepm_modmul.sv @@
// pipelined barrett modular multiply-add, four stages
`default_nettype none
module fepm_modmul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [29:0] a,
  input  wire logic [29:0] b,
  input  wire logic [31:0] addend,
  input  wire logic        sel_exp,
  output logic             done,
  output logic [29:0]      res
);
  import fepm_pkg::*;

  logic        v1, v2, v3, v4;
  logic        s1, s2, s3;
  logic [59:0] p1;
  logic [30:0] q2;
  logic [31:0] plo2;
  logic [31:0] r3;

  logic [59:0] a60, b60;
  logic [61:0] prod2;
  logic [61:0] p_hi62, mu62;
  logic [31:0] q32, m32, qm32;

  always_comb begin
    a60    = {30'd0, a};
    b60    = {30'd0, b};
    p_hi62 = {31'd0, p1[59:29]};
    mu62   = {31'd0, (s1 ? MU_E : MU_P)};
    prod2  = p_hi62 * mu62;
    q32    = {1'b0, q2};
    m32    = {2'b00, (s2 ? MOD_E : MOD_P)};
    qm32   = q32 * m32;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    p1   <= a60 * b60 + {28'd0, addend};
    s1   <= sel_exp;
    q2   <= prod2[61:31];
    plo2 <= p1[31:0];
    s2   <= s1;
    r3   <= plo2 - qm32;
    s3   <= s2;
    res  <= mod_fix(r3, (s3 ? MOD_E : MOD_P));
  end

  assign done = v4;

endmodule
`default_nettype wire

@@ rtl/fepm_datapath.sv @@
// operand registers, fibonacci doubling and exponent ladder datapath
`default_nettype none
module fepm_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fepm_pkg::item_t  item,
  input  wire fepm_pkg::cmd_t   cmd,
  output fepm_pkg::status_t     status,
  output fepm_pkg::result_t     result
);
  import fepm_pkg::*;

  logic [IN_W-1:0]      w_in, x_in, k_sh;
  logic [FIB_CNT_W-1:0] fib_cnt;
  logic [POW_CNT_W-1:0] pow_cnt;
  logic [29:0] fa, fb, t_r, s_r, c_r, d_r;
  logic [29:0] w_r, x_r, wx_r, ea, eb, acc;
  logic        bad;

  logic [29:0] mm_a, mm_b, mm_res, pow_base;
  logic [31:0] mm_add;
  logic        mm_sel, mm_done;
  logic [31:0] t_raw;
  logic [29:0] t_next, cd_sum;

  always_comb begin
    t_raw  = {1'b0, fb, 1'b0} + {2'b00, MOD_E} - {2'b00, fa};
    t_next = mod_fix(t_raw, MOD_E);
    cd_sum = mod_fix({2'b00, c_r} + {2'b00, d_r}, MOD_E);
    case ({ea[29], eb[29]})
      2'b10:   pow_base = w_r;
      2'b01:   pow_base = x_r;
      default: pow_base = wx_r;
    endcase
  end

  always_comb begin
    mm_a   = '0;
    mm_b   = '0;
    mm_add = '0;
    mm_sel = 1'b0;
    case (cmd.op)
      OP_RED_W: begin
        mm_a   = w_in[61:32];
        mm_b   = TWO32_P;
        mm_add = w_in[31:0];
      end
      OP_RED_X: begin
        mm_a   = x_in[61:32];
        mm_b   = TWO32_P;
        mm_add = x_in[31:0];
      end
      OP_WX: begin
        mm_a = w_r;
        mm_b = x_r;
      end
      OP_FIB_S: begin
        mm_a   = fb;
        mm_b   = fb;
        mm_sel = 1'b1;
      end
      OP_FIB_D: begin
        mm_a   = fa;
        mm_b   = fa;
        mm_add = {2'b00, s_r};
        mm_sel = 1'b1;
      end
      OP_FIB_T: begin
        mm_a   = fa;
        mm_b   = t_r;
        mm_sel = 1'b1;
      end
      OP_POW_SQ: begin
        mm_a = acc;
        mm_b = acc;
      end
      OP_POW_MUL: begin
        mm_a = acc;
        mm_b = pow_base;
      end
      default: begin
        mm_a = '0;
      end
    endcase
  end

  fepm_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start),
    .a       (mm_a),
    .b       (mm_b),
    .addend  (mm_add),
    .sel_exp (mm_sel),
    .done    (mm_done),
    .res     (mm_res)
  );

  always_ff @(posedge clk) begin
    t_r <= t_next;
    if (cmd.load) begin
      w_in    <= item.base_w;
      x_in    <= item.base_x;
      k_sh    <= item.index_n - 62'd1;
      fa      <= '0;
      fb      <= 30'd1;
      fib_cnt <= '0;
      acc     <= '0;
      bad     <= status.index_zero;
    end
    if (mm_done) begin
      case (cmd.op)
        OP_RED_W:   w_r  <= mm_res;
        OP_RED_X:   x_r  <= mm_res;
        OP_WX:      wx_r <= mm_res;
        OP_FIB_S:   s_r  <= mm_res;
        OP_FIB_D:   d_r  <= mm_res;
        OP_FIB_T:   c_r  <= mm_res;
        OP_POW_SQ:  acc  <= mm_res;
        OP_POW_MUL: acc  <= mm_res;
        default:    s_r  <= s_r;
      endcase
    end
    if (cmd.fib_step) begin
      if (k_sh[IN_W-1]) begin
        fa <= d_r;
        fb <= cd_sum;
      end else begin
        fa <= c_r;
        fb <= d_r;
      end
      k_sh    <= {k_sh[IN_W-2:0], 1'b0};
      fib_cnt <= fib_cnt + 1'b1;
    end
    if (cmd.pow_init) begin
      ea      <= fa;
      eb      <= fb;
      acc     <= 30'd1;
      pow_cnt <= '0;
    end
    if (cmd.pow_step) begin
      ea      <= {ea[28:0], 1'b0};
      eb      <= {eb[28:0], 1'b0};
      pow_cnt <= pow_cnt + 1'b1;
    end
    if (cmd.out_load) begin
      result.product_mod <= acc;
      result.bad_index   <= bad;
    end
  end

  always_comb begin
    status.index_zero = (item.index_n == '0);
    status.mul_done   = mm_done;
    status.fib_last   = (fib_cnt == FIB_CNT_W'(FIB_STEPS - 1));
    status.pow_sel    = ea[29] | eb[29];
    status.pow_last   = (pow_cnt == POW_CNT_W'(POW_STEPS - 1));
  end

endmodule
`default_nettype wire

@@ rtl/fepm_ctrl.sv @@
// sequencing state machine and handshake control
`default_nettype none
module fepm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  output logic                   result_valid,
  input  wire logic              result_ready,
  input  wire fepm_pkg::status_t status,
  output fepm_pkg::cmd_t         cmd
);
  import fepm_pkg::*;

  state_t state, state_next;
  logic   issued;
  logic   out_valid;
  logic   accept;
  logic   out_free;

  assign item_ready   = (state == S_IDLE);
  assign accept       = item_valid & item_ready;
  assign out_free     = ~out_valid | result_ready;
  assign result_valid = out_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (accept) state_next = status.index_zero ? S_FINISH : S_RED_W;
      S_RED_W:    if (status.mul_done) state_next = S_RED_X;
      S_RED_X:    if (status.mul_done) state_next = S_WX;
      S_WX:       if (status.mul_done) state_next = S_FIB_S;
      S_FIB_S:    if (status.mul_done) state_next = S_FIB_D;
      S_FIB_D:    if (status.mul_done) state_next = S_FIB_T;
      S_FIB_T:    if (status.mul_done) state_next = S_FIB_NEXT;
      S_FIB_NEXT: state_next = status.fib_last ? S_POW_INIT : S_FIB_S;
      S_POW_INIT: state_next = S_POW_SQ;
      S_POW_SQ: begin
        if (status.mul_done) state_next = status.pow_sel ? S_POW_MUL : S_POW_NEXT;
      end
      S_POW_MUL:  if (status.mul_done) state_next = S_POW_NEXT;
      S_POW_NEXT: state_next = status.pow_last ? S_FINISH : S_POW_SQ;
      S_FINISH:   if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.load     = accept;
    case (state)
      S_RED_W:    cmd.op = OP_RED_W;
      S_RED_X:    cmd.op = OP_RED_X;
      S_WX:       cmd.op = OP_WX;
      S_FIB_S:    cmd.op = OP_FIB_S;
      S_FIB_D:    cmd.op = OP_FIB_D;
      S_FIB_T:    cmd.op = OP_FIB_T;
      S_FIB_NEXT: cmd.fib_step = 1'b1;
      S_POW_INIT: cmd.pow_init = 1'b1;
      S_POW_SQ:   cmd.op = OP_POW_SQ;
      S_POW_MUL:  cmd.op = OP_POW_MUL;
      S_POW_NEXT: cmd.pow_step = 1'b1;
      S_FINISH:   cmd.out_load = out_free;
      default:    cmd.op = OP_NONE;
    endcase
    cmd.start = (cmd.op != OP_NONE) & ~issued;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (status.mul_done) begin
        issued <= 1'b0;
      end else if (cmd.start) begin
        issued <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fibonacci_exponent_modular_power_top.sv @@
// top level of the fibonacci exponent modular power block
// One transaction in gives one transaction out: product_mod = w^F(n-1) * x^F(n) mod 1000000007,
// with the Fibonacci exponents found by fast doubling modulo 1000000006 and the two powers
// taken together in one square-and-multiply ladder; index_n of 0 returns 0 with bad_index set.
// All products run through one four-stage Barrett multiply unit, one product at a time: a
// transaction takes 62 doubling steps of three products, then 30 ladder steps of one or two,
// while a zero index skips them all. Items are taken one at a time; a finished result sits
// in an output register so the next item can start while it waits.
`default_nettype none
module fibonacci_exponent_modular_power_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire fepm_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output fepm_pkg::result_t      result
);
  import fepm_pkg::*;

  cmd_t    cmd;
  status_t status;

  fepm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  fepm_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule
`default_nettype wire

@@ rtl/fepm_checker.sv @@
// port-level checker for the top level and its bind
`default_nettype none
module fepm_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire fepm_pkg::result_t result
);
  import fepm_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second transaction taken while busy");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_index |-> result.product_mod == '0)
    else $error("error result carries nonzero product");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.product_mod < MOD_P)
    else $error("product not reduced");

endmodule

bind fibonacci_exponent_modular_power_top fepm_checker u_fepm_checker (.*);
`default_nettype wire

@@ tb/fibonacci_exponent_modular_power_top_tb.sv @@
// testbench for the fibonacci exponent modular power block: random and corner transactions
`default_nettype none
module fibonacci_exponent_modular_power_top_tb;
  import fepm_pkg::*;

  localparam longint unsigned PRIME = 64'd1000000007;
  localparam longint unsigned EXPM  = 64'd1000000006;
  localparam longint unsigned MASK62 = (64'd1 << 62) - 1;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  item_t item;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;

  result_t expected_q[$];
  int err_count = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  fibonacci_exponent_modular_power_top u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    return (a * b) % m;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e);
    longint unsigned r;
    r = 1;
    b = b % PRIME;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, PRIME);
      b = mul_mod(b, b, PRIME);
      e = e >> 1;
    end
    return r;
  endfunction

  // fibonacci matrix power mod EXPM, then the two-base product mod PRIME
  function automatic result_t fib_power_product(item_t it);
    longint unsigned acc[4];
    longint unsigned bm[4];
    longint unsigned t[4];
    longint unsigned k;
    result_t r;
    r = '0;
    if (it.index_n == 0) begin
      r.bad_index = 1'b1;
      return r;
    end
    k = (64'(it.index_n) & MASK62) - 1;
    acc = '{1, 0, 0, 1};
    bm = '{1, 1, 1, 0};
    while (k != 0) begin
      if (k[0]) begin
        t[0] = (mul_mod(acc[0], bm[0], EXPM) + mul_mod(acc[1], bm[2], EXPM)) % EXPM;
        t[1] = (mul_mod(acc[0], bm[1], EXPM) + mul_mod(acc[1], bm[3], EXPM)) % EXPM;
        t[2] = (mul_mod(acc[2], bm[0], EXPM) + mul_mod(acc[3], bm[2], EXPM)) % EXPM;
        t[3] = (mul_mod(acc[2], bm[1], EXPM) + mul_mod(acc[3], bm[3], EXPM)) % EXPM;
        acc = t;
      end
      t[0] = (mul_mod(bm[0], bm[0], EXPM) + mul_mod(bm[1], bm[2], EXPM)) % EXPM;
      t[1] = (mul_mod(bm[0], bm[1], EXPM) + mul_mod(bm[1], bm[3], EXPM)) % EXPM;
      t[2] = (mul_mod(bm[2], bm[0], EXPM) + mul_mod(bm[3], bm[2], EXPM)) % EXPM;
      t[3] = (mul_mod(bm[2], bm[1], EXPM) + mul_mod(bm[3], bm[3], EXPM)) % EXPM;
      bm = t;
      k = k >> 1;
    end
    r.product_mod = RES_W'(mul_mod(pow_mod(64'(it.base_w), acc[1]),
                                   pow_mod(64'(it.base_x), acc[0]), PRIME));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  task automatic send_item(item_t it);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99, 0) < send_idle_pct) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    expected_q.push_back(fib_power_product(it));
  endtask

  // receiver: random stall, compare each transaction against the oldest prediction
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(result.product_mod), 64'd0);
      end else begin
        if (result.product_mod !== expected_q[0].product_mod)
          report_mismatch("product_mod", 64'(result.product_mod),
                          64'(expected_q[0].product_mod));
        if (result.bad_index !== expected_q[0].bad_index)
          report_mismatch("bad_index", 64'(result.bad_index), 64'(expected_q[0].bad_index));
        void'(expected_q.pop_front());
      end
    end
    result_ready <= (recv_idle_pct == 0) || ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [61:0] rand62();
    return 62'({$urandom(), $urandom()});
  endfunction

  function automatic logic [61:0] rand_index();
    case ($urandom_range(3, 0))
      0: return 62'($urandom_range(20, 0));
      1: return 62'($urandom());
      default: return rand62();
    endcase
  endfunction

  function automatic logic [61:0] rand_base();
    case ($urandom_range(5, 0))
      0: return 62'(PRIME) * 62'($urandom_range(3, 0));
      1: return 62'($urandom_range(2, 0));
      2: return 62'($urandom());
      default: return rand62();
    endcase
  endfunction

  task automatic send_one(logic [61:0] w, logic [61:0] x, logic [61:0] n);
    item_t it;
    it.base_w = w;
    it.base_x = x;
    it.index_n = n;
    send_item(it);
  endtask

  task automatic test_zero_index();
    send_one(62'd5, 62'd7, 62'd0);
    send_one(62'(MASK62), 62'(MASK62), 62'd0);
  endtask

  task automatic test_index_one();
    send_one(62'd123, 62'd456, 62'd1);
    send_one(62'(MASK62), 62'(MASK62), 62'd1);
    send_one(62'(PRIME), 62'(PRIME) + 62'd9, 62'd1);
  endtask

  task automatic test_zero_exponent();
    send_one(62'd0, 62'd0, 62'd1);
    send_one(62'd0, 62'd3, 62'd2);
    send_one(62'(PRIME) * 62'd2, 62'd0, 62'd3);
  endtask

  task automatic test_extremes();
    send_one(62'(MASK62), 62'(MASK62), 62'(MASK62));
    send_one(62'd0, 62'd0, 62'(MASK62));
    send_one(62'(PRIME - 1), 62'(PRIME - 1), 62'(EXPM));
    send_one(62'd2, 62'd3, 62'(EXPM) + 62'd1);
    send_one(62'd1, 62'd1, 62'd2);
    send_one(62'd2, 62'd2, 62'd50);
    send_one(62'h2AAAAAAAAAAAAAAA, 62'h1555555555555555, 62'h1555555555555555);
    send_one(62'h1555555555555555, 62'h2AAAAAAAAAAAAAAA, 62'h2AAAAAAAAAAAAAAA);
  endtask

  task automatic test_random(int count);
    repeat (count) send_one(rand_base(), rand_base(), rand_index());
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    send_idle_pct = 35;
    recv_idle_pct = 45;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_zero_index();
    test_index_one();
    test_zero_exponent();
    test_extremes();
    test_random(160);
    send_idle_pct = 45;
    recv_idle_pct = 35;
    test_random(160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(160);
    item_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
rtl/fepm_pkg.sv
rtl/fepm_modmul.sv
rtl/fepm_datapath.sv
rtl/fepm_ctrl.sv
rtl/fibonacci_exponent_modular_power_top.sv
rtl/fepm_checker.sv
tb/fibonacci_exponent_modular_power_top_tb.sv
